@@ sv/srsw_pkg.sv @@
// Shared types, constants and codes for the selective-repeat sender window.
package srsw_pkg;

  // Ring depth and the field widths.
  localparam int MAX_WINDOW = 32;
  localparam int SEQ_BITS   = 16;
  localparam int OFF_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 6;
  localparam int CNT_W      = 16;

  // Configuration register byte addresses.
  localparam int          ADDR_W      = 3;
  localparam logic [2:0]  ADDR_TOTAL  = 3'd0;
  localparam logic [2:0]  ADDR_WINDOW = 3'd4;

  // Register reset values.
  localparam logic [SEQ_BITS-1:0] TOTAL_RESET  = 16'd8;
  localparam logic [WIN_W-1:0]    WINDOW_RESET = 6'd4;

  // Result status codes.
  localparam logic [1:0] ST_ACK     = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SLIDE
  } state_t;

  // Control from the sequencer to the row of ack cells.
  typedef struct packed {
    logic             shift;
    logic             mark;
    logic [OFF_W-1:0] offset;
  } ring_ctrl_t;

  // Status from the row of ack cells back to the sequencer.
  typedef struct packed {
    logic head;
    logic sel_bit;
  } ring_stat_t;

endpackage

@@ sv/srsw_cell.sv @@
// One ack cell: holds the ack bit of one window position.
module srsw_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,
  input  logic mark_here,
  input  logic next_bit,
  output logic bit_r
);

  // On a shift the cell takes its upper neighbor's bit; a mark sets it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else if (shift) begin
      bit_r <= next_bit;
    end else if (mark_here) begin
      bit_r <= 1'b1;
    end
  end

endmodule

@@ sv/srsw_chain.sv @@
// Row of ack cells; cell 0 always holds the frame just above the base.
module srsw_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  srsw_pkg::ring_ctrl_t ctrl,
  output srsw_pkg::ring_stat_t stat
);
  import srsw_pkg::*;

  logic [MAX_WINDOW-1:0] bits;
  logic [MAX_WINDOW-1:0] next_bits;

  // Each cell hands its bit down by one on a shift; the top cell fills with zero.
  assign next_bits = {1'b0, bits[MAX_WINDOW-1:1]};

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    srsw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (ctrl.shift),
      .mark_here (ctrl.mark && (ctrl.offset == OFF_W'(i))),
      .next_bit  (next_bits[i]),
      .bit_r     (bits[i])
    );
  end

  // Head cell drives the slide; the selected cell reports an earlier ack.
  assign stat.head    = bits[0];
  assign stat.sel_bit = bits[ctrl.offset];

endmodule

@@ sv/selective_repeat_sender_window_top.sv @@
// Top level of the selective-repeat sender window with its register port.
// Each input transfer reports an ack or a timeout for one frame and yields one
// result transfer. An item is taken, its event is evaluated, the window base
// slides by k positions (0 to 32) in the row of 32 ack cells, which shifts by
// one position a cycle, and the result is placed in the output register once
// that register is free. The next item is taken while a result still waits at
// the output.
module selective_repeat_sender_window_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: frame_number [15:0], timed_out [16], zero [23:17]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [srsw_pkg::IN_DATA_W-1:0] in_tdata,
  // out_tdata: event_status [1:0], window_base [17:2], retransmissions [33:18],
  // all_done [34], zero [39:35]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srsw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import srsw_pkg::*;

  state_t              state_r, state_nxt;
  logic [SEQ_BITS-1:0] total_r;
  logic [WIN_W-1:0]    window_r;
  logic [SEQ_BITS-1:0] frame_r;
  logic                timed_r;
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]    retry_r, retry_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  ring_ctrl_t          ring_ctrl;
  ring_stat_t          ring_stat;

  logic [WIN_W-1:0]    win_eff;
  logic [SEQ_BITS:0]   frame_gap;
  logic [SEQ_BITS-1:0] off_full;
  logic                in_window;
  logic                can_slide;
  logic                cfg_wr;

  // Register port: writes complete in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= TOTAL_RESET;
      window_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_TOTAL) begin
        total_r <= cfg_pwdata[SEQ_BITS-1:0];
      end else if (cfg_paddr == ADDR_WINDOW) begin
        window_r <= cfg_pwdata[WIN_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_TOTAL:  cfg_prdata = 32'(total_r);
      ADDR_WINDOW: cfg_prdata = 32'(window_r);
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Window test for the held event.
  assign win_eff   = (window_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_r;
  assign frame_gap = {1'b0, frame_r} - {1'b0, base_r};
  assign off_full  = frame_r - base_r - SEQ_BITS'(1);
  assign in_window = (frame_r > base_r) && (frame_gap <= (SEQ_BITS+1)'(win_eff))
                     && (frame_r <= total_r);
  assign can_slide = (base_r < total_r) && ring_stat.head;

  srsw_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ring_ctrl),
    .stat  (ring_stat)
  );

  // Input register for the accepted event.
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      frame_r <= in_tdata[SEQ_BITS-1:0];
      timed_r <= in_tdata[SEQ_BITS];
    end
  end

  // Sequencer: evaluate the event, slide the base one step a cycle, then emit the result.
  always_comb begin
    state_nxt        = state_r;
    base_nxt         = base_r;
    retry_nxt        = retry_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    ring_ctrl.shift  = 1'b0;
    ring_ctrl.mark   = 1'b0;
    ring_ctrl.offset = off_full[OFF_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        status_nxt = ST_IGNORED;
        if (in_window && !ring_stat.sel_bit) begin
          if (timed_r) begin
            status_nxt = ST_TIMEOUT;
            if (retry_r != {CNT_W{1'b1}}) begin
              retry_nxt = retry_r + CNT_W'(1);
            end
          end else begin
            status_nxt     = ST_ACK;
            ring_ctrl.mark = 1'b1;
          end
        end
        state_nxt = S_SLIDE;
      end
      S_SLIDE: begin
        if (can_slide) begin
          ring_ctrl.shift = 1'b1;
          base_nxt        = base_r + SEQ_BITS'(1);
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({(base_r >= total_r), retry_r, base_r, status_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      retry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      retry_r     <= retry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/srsw_checker.sv @@
// Port-level checks for the sender window, bound to the top level.
module srsw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [srsw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_pready
);
  import srsw_pkg::*;

  // A result held back by the consumer stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The status field carries one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_ACK) || (out_tdata[1:0] == ST_TIMEOUT)
                   || (out_tdata[1:0] == ST_IGNORED))
    else $error("undefined status code");

  // One event at a time: after an input transfer the block is busy.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second event taken while the first is in work");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // The register port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

@@ dv/tb_selective_repeat_sender_window_top.sv @@
// Self-checking testbench for the selective-repeat sender window top level.
module tb_selective_repeat_sender_window_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PLAN_ROWS    = 34;

  // One result as it sits in out_tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic                done;
    logic [CNT_W-1:0]    retries;
    logic [SEQ_BITS-1:0] base;
    logic [1:0]          status;
  } window_result_t;

  typedef struct {
    bit             known;
    window_result_t res;
  } typed_result_t;

  typedef enum logic [1:0] {
    DO_ACK,
    DO_TIMEOUT,
    SET_TOTAL,
    SET_WINDOW
  } plan_op_e;

  typedef struct packed {
    plan_op_e            op;
    logic [15:0]         value;
    logic                known;
    logic [1:0]          status;
    logic [SEQ_BITS-1:0] base;
    logic [CNT_W-1:0]    retries;
    logic                done;
  } plan_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the window state and its registers.
  bit                  acked_slots [MAX_WINDOW];
  int unsigned         base_now    = 0;
  int unsigned         retries_now = 0;
  logic [SEQ_BITS-1:0] total_cfg   = TOTAL_RESET;
  logic [WIN_W-1:0]    window_cfg  = WINDOW_RESET;

  window_result_t pending_results [$];
  typed_result_t  given_results [$];
  int             n_fail      = 0;
  int             quiet_count = 0;
  bit             steady      = 1'b0;

  // Directed rows; typed results are the ones that follow plainly from the reset state.
  plan_row_t plan [PLAN_ROWS] = '{
    '{DO_ACK,     16'd0,     1'b1, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_TIMEOUT, 16'd1,     1'b1, ST_TIMEOUT, 16'd0,  16'd1, 1'b0},
    '{DO_ACK,     16'd5,     1'b1, ST_IGNORED, 16'd0,  16'd1, 1'b0},
    '{DO_ACK,     16'd2,     1'b1, ST_ACK,     16'd0,  16'd1, 1'b0},
    '{DO_TIMEOUT, 16'd2,     1'b1, ST_IGNORED, 16'd0,  16'd1, 1'b0},
    '{DO_ACK,     16'd1,     1'b1, ST_ACK,     16'd2,  16'd1, 1'b0},
    '{DO_ACK,     16'd65535, 1'b1, ST_IGNORED, 16'd2,  16'd1, 1'b0},
    '{DO_ACK,     16'd3,     1'b1, ST_ACK,     16'd3,  16'd1, 1'b0},
    '{DO_ACK,     16'd6,     1'b1, ST_ACK,     16'd3,  16'd1, 1'b0},
    '{DO_ACK,     16'd5,     1'b1, ST_ACK,     16'd3,  16'd1, 1'b0},
    '{DO_ACK,     16'd4,     1'b1, ST_ACK,     16'd6,  16'd1, 1'b0},
    '{DO_ACK,     16'd8,     1'b1, ST_ACK,     16'd6,  16'd1, 1'b0},
    '{DO_ACK,     16'd7,     1'b1, ST_ACK,     16'd8,  16'd1, 1'b1},
    '{DO_TIMEOUT, 16'd9,     1'b1, ST_IGNORED, 16'd8,  16'd1, 1'b1},
    '{SET_TOTAL,  16'd0,     1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd1,     1'b1, ST_IGNORED, 16'd8,  16'd1, 1'b1},
    '{SET_TOTAL,  16'd65535, 1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{SET_WINDOW, 16'd0,     1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd9,     1'b1, ST_IGNORED, 16'd8,  16'd1, 1'b0},
    '{SET_WINDOW, 16'd63,    1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd40,    1'b1, ST_ACK,     16'd8,  16'd1, 1'b0},
    '{DO_ACK,     16'd41,    1'b1, ST_IGNORED, 16'd8,  16'd1, 1'b0},
    '{DO_TIMEOUT, 16'd40,    1'b1, ST_IGNORED, 16'd8,  16'd1, 1'b0},
    '{DO_TIMEOUT, 16'd9,     1'b1, ST_TIMEOUT, 16'd8,  16'd2, 1'b0},
    '{SET_WINDOW, 16'd32,    1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd9,     1'b1, ST_ACK,     16'd9,  16'd2, 1'b0},
    '{SET_WINDOW, 16'd1,     1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd11,    1'b1, ST_IGNORED, 16'd9,  16'd2, 1'b0},
    '{DO_ACK,     16'd10,    1'b1, ST_ACK,     16'd10, 16'd2, 1'b0},
    '{SET_WINDOW, 16'd33,    1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_TIMEOUT, 16'd32768, 1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_TIMEOUT, 16'd11,    1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{SET_TOTAL,  16'd1,     1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0},
    '{DO_ACK,     16'd11,    1'b0, ST_IGNORED, 16'd0,  16'd0, 1'b0}
  };

  selective_repeat_sender_window_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Apply one ack or timeout to the shadow window, slide the base and form the result.
  function automatic window_result_t window_apply_event(logic [15:0] frame, logic timed_out);
    int unsigned    win;
    int unsigned    fnum;
    window_result_t res;
    win  = (window_cfg > MAX_WINDOW) ? MAX_WINDOW : window_cfg;
    fnum = frame;
    res.status = ST_IGNORED;
    if (fnum > base_now && fnum <= base_now + win && fnum <= total_cfg) begin
      if (!acked_slots[(fnum - 1) % MAX_WINDOW]) begin
        if (timed_out) begin
          if (retries_now < 32'hFFFF) retries_now++;
          res.status = ST_TIMEOUT;
        end else begin
          acked_slots[(fnum - 1) % MAX_WINDOW] = 1'b1;
          res.status = ST_ACK;
        end
      end
    end
    while (base_now < total_cfg && acked_slots[base_now % MAX_WINDOW]) begin
      acked_slots[base_now % MAX_WINDOW] = 1'b0;
      base_now++;
    end
    res.base    = 16'(base_now);
    res.retries = 16'(retries_now);
    res.done    = (base_now >= total_cfg);
    return res;
  endfunction

  // Frame numbers mostly inside the window, some just outside, some at or just below the base, a few anywhere.
  function automatic logic [15:0] pick_frame();
    int unsigned win;
    int unsigned roll;
    win  = (window_cfg > MAX_WINDOW) ? MAX_WINDOW : window_cfg;
    roll = $urandom_range(99);
    if (roll < 80) begin
      return 16'(base_now + $urandom_range(1, win + 1));
    end else if (roll < 87) begin
      return 16'(base_now + $urandom_range(win + 1, win + 6));
    end else if (roll < 90) begin
      return 16'(base_now - $urandom_range(0, 3));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Present one event and hold it until the block takes it.
  task automatic send_event(input logic [15:0] frame, input logic timed_out,
                            input bit known, input window_result_t typed);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 34) gap++;
    end
    given_results.push_back('{known, typed});
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - 17){1'b0}}, timed_out, frame};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_TOTAL) begin
      total_cfg = value[SEQ_BITS-1:0];
    end else if (addr == ADDR_WINDOW) begin
      window_cfg = value[WIN_W-1:0];
    end
  endtask

  // Result sink backpressure.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 34);
  end

  // Check result transfers, predict accepted events and watch for a stall.
  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    typed_result_t  given;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[34:0];
        if (pending_results.size() == 0) begin
          $error("result transfer with no expected result: %h", out_tdata);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("event_status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
          end
          if (got.base !== want.base) begin
            $error("window_base: expected %0d, got %0d", want.base, got.base);
            n_fail++;
          end
          if (got.retries !== want.retries) begin
            $error("retransmissions: expected %0d, got %0d", want.retries, got.retries);
            n_fail++;
          end
          if (got.done !== want.done) begin
            $error("all_done: expected %0d, got %0d", want.done, got.done);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want  = window_apply_event(in_tdata[15:0], in_tdata[16]);
        given = given_results.pop_front();
        if (given.known) want = given.res;
        pending_results.push_back(want);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    window_result_t typed;
    int             n_items;
    int unsigned    win_pick;
    int unsigned    total_pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].op)
        SET_TOTAL: begin
          drain();
          write_reg(ADDR_TOTAL, {16'd0, plan[i].value});
        end
        SET_WINDOW: begin
          drain();
          write_reg(ADDR_WINDOW, {16'd0, plan[i].value});
        end
        default: begin
          typed = {plan[i].done, plan[i].retries, plan[i].base, plan[i].status};
          send_event(plan[i].value, plan[i].op == DO_TIMEOUT, plan[i].known, typed);
        end
      endcase
    end

    // Random phases, each under its own window and transfer length.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       win_pick = 4;
        1:       win_pick = 32;
        2:       win_pick = 63;
        3:       win_pick = 1;
        4:       win_pick = 0;
        5:       win_pick = $urandom_range(2, 31);
        6:       win_pick = 32;
        default: win_pick = $urandom_range(33, 62);
      endcase
      drain();
      total_pick = (phase == 6) ? base_now : base_now + $urandom_range(80, 400);
      n_items    = (phase == 4 || phase == 6) ? 30 : 240;
      steady     = (phase == 1);
      write_reg(ADDR_TOTAL, total_pick);
      write_reg(ADDR_WINDOW, win_pick);
      repeat (n_items) send_event(pick_frame(), $urandom_range(99) < 30, 1'b0, '0);
    end

    drain();
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
